// ===== src/bddp_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce double-press package
// Shared constants, register indexes and helper functions for the debouncer.
// ----------------------------------------------------------------------------
package bddp_pkg;

   localparam int TIMER_WIDTH = 16;
   localparam int LEVEL_WIDTH = 3;
   localparam int ELAPSED_WIDTH = 8;
   localparam int EVENT_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [LEVEL_WIDTH-1:0] level_type;
   typedef logic [ELAPSED_WIDTH-1:0] elapsed_type;
   typedef logic [EVENT_WIDTH-1:0] event_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_DEBOUNCE_PERIOD = 1'd0;
   localparam csr_index_type CSR_REPEAT_WINDOW = 1'd1;

   localparam timer_type DEBOUNCE_PERIOD_RESET = 16'd40;
   localparam timer_type REPEAT_WINDOW_RESET = 16'd500;
   localparam timer_type TIMER_MAX = 16'hFFFF;

   localparam level_type ALL_RELEASED = 3'd7;
   localparam level_type LEVELS_BUTTON_ONE = 3'd6;
   localparam level_type LEVELS_BUTTON_TWO = 3'd5;
   localparam level_type LEVELS_BUTTON_THREE = 3'd3;

   localparam event_type EVENT_NONE = 2'd0;
   localparam event_type EVENT_BUTTON_ONE = 2'd1;
   localparam event_type EVENT_BUTTON_TWO = 2'd2;
   localparam event_type EVENT_BUTTON_THREE = 2'd3;

   function automatic timer_type sat_add(input timer_type a, input elapsed_type b);
      logic [TIMER_WIDTH:0] sum;
      sum = {1'b0, a} + {{(TIMER_WIDTH + 1 - ELAPSED_WIDTH){1'b0}}, b};
      sat_add = sum[TIMER_WIDTH] ? TIMER_MAX : sum[TIMER_WIDTH-1:0];
   endfunction

   function automatic event_type single_button(input level_type levels);
      event_type code;
      unique case (levels)
         LEVELS_BUTTON_ONE: code = EVENT_BUTTON_ONE;
         LEVELS_BUTTON_TWO: code = EVENT_BUTTON_TWO;
         LEVELS_BUTTON_THREE: code = EVENT_BUTTON_THREE;
         default: code = EVENT_NONE;
      endcase
      single_button = code;
   endfunction

endpackage

// ===== src/button_debounce_double_press_core.sv =====
// An accepted tick's result is registered in the output register, or in the
// skid register while a result is stalled; req_stall rises once it is full.
// One tick per cycle while req_stall is low, each a single pass of logic.
// Reset is synchronous, active high: timers clear, samples read all released,
// registers return to 40 ms and 500 ms, and no result is pending.
// ----------------------------------------------------------------------------
// Button debounce double-press core
// Samples three active-low buttons every debounce interval, reports single
// presses and cancels a repeated press of the same button inside a window.
// ----------------------------------------------------------------------------
module button_debounce_double_press_core
   import bddp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  csr_index_type csr_index,
   input  timer_type     csr_write_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  elapsed_type   req_elapsed_ms,
   input  level_type     req_button_levels,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output event_type     rsp_event_res,
   output logic          rsp_cancelled
);

   timer_type debounce_period_ff;
   timer_type repeat_window_ff;

   timer_type sample_timer_ff, sample_timer_in;
   timer_type repeat_timer_ff, repeat_timer_in;
   level_type current_sample_ff, current_sample_in;
   level_type previous_sample_ff, previous_sample_in;
   logic      pressed_flag_ff, pressed_flag_in;
   event_type remembered_button_ff, remembered_button_in;

   event_type event_in;
   logic      cancelled_in;

   logic      out_valid_ff;
   event_type out_event_ff;
   logic      out_cancelled_ff;
   logic      skid_valid_ff;
   event_type skid_event_ff;
   logic      skid_cancelled_ff;

   logic      accept;
   logic      pop;
   timer_type sample_sum;
   timer_type repeat_step;
   event_type button_code;

   assign accept = req_valid && !skid_valid_ff;
   assign pop = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_event_res = out_event_ff;
   assign rsp_cancelled = out_cancelled_ff;

   always_comb begin
      sample_sum = sat_add(sample_timer_ff, req_elapsed_ms);
      button_code = single_button(req_button_levels);

      sample_timer_in = sample_sum;
      repeat_timer_in = repeat_timer_ff;
      remembered_button_in = remembered_button_ff;
      current_sample_in = current_sample_ff;
      previous_sample_in = previous_sample_ff;
      pressed_flag_in = pressed_flag_ff;
      event_in = EVENT_NONE;
      cancelled_in = 1'b0;

      if (repeat_timer_ff >= repeat_window_ff) begin
         repeat_timer_in = '0;
         remembered_button_in = EVENT_NONE;
      end else if (repeat_timer_ff != '0) begin
         repeat_timer_in = sat_add(repeat_timer_ff, req_elapsed_ms);
      end
      repeat_step = repeat_timer_in;

      if (sample_sum >= debounce_period_ff) begin
         sample_timer_in = '0;
         previous_sample_in = current_sample_ff;
         current_sample_in = req_button_levels;
         if (req_button_levels == current_sample_ff) begin
            if (req_button_levels != ALL_RELEASED) begin
               if (!pressed_flag_ff) begin
                  if (button_code == EVENT_NONE) begin
                     pressed_flag_in = 1'b0;
                  end else if (repeat_step != '0 && remembered_button_in == button_code) begin
                     pressed_flag_in = 1'b1;
                     repeat_timer_in = '0;
                     remembered_button_in = EVENT_NONE;
                     cancelled_in = 1'b1;
                  end else begin
                     pressed_flag_in = 1'b1;
                     remembered_button_in = button_code;
                     event_in = button_code;
                  end
               end
            end else if (pressed_flag_ff) begin
               repeat_timer_in = sat_add(repeat_step, req_elapsed_ms);
               pressed_flag_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_period_ff <= DEBOUNCE_PERIOD_RESET;
         repeat_window_ff <= REPEAT_WINDOW_RESET;
         sample_timer_ff <= '0;
         repeat_timer_ff <= '0;
         current_sample_ff <= ALL_RELEASED;
         previous_sample_ff <= ALL_RELEASED;
         pressed_flag_ff <= 1'b0;
         remembered_button_ff <= EVENT_NONE;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEBOUNCE_PERIOD: debounce_period_ff <= csr_write_data;
               CSR_REPEAT_WINDOW: repeat_window_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (accept) begin
            sample_timer_ff <= sample_timer_in;
            repeat_timer_ff <= repeat_timer_in;
            current_sample_ff <= current_sample_in;
            previous_sample_ff <= previous_sample_in;
            pressed_flag_ff <= pressed_flag_in;
            remembered_button_ff <= remembered_button_in;
            if (out_valid_ff && !pop) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (out_valid_ff && !pop) begin
            skid_event_ff <= event_in;
            skid_cancelled_ff <= cancelled_in;
         end else begin
            out_event_ff <= event_in;
            out_cancelled_ff <= cancelled_in;
         end
      end else if (pop && skid_valid_ff) begin
         out_event_ff <= skid_event_ff;
         out_cancelled_ff <= skid_cancelled_ff;
      end
   end

endmodule

// ===== src/bddp_checker.sv =====
// ----------------------------------------------------------------------------
// Button debounce double-press checker
// Port-level assertions on the debouncer core, attached by a bind statement.
// ----------------------------------------------------------------------------
module bddp_checker
   import bddp_pkg::*;
(
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_stall,
   input logic      rsp_valid,
   input logic      rsp_stall,
   input event_type rsp_event_res,
   input logic      rsp_cancelled
);

   a_cancel_has_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cancelled |-> rsp_event_res == EVENT_NONE)
      else $error("A cancelled result carries a button event.");

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result is pending right after reset.");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("The input is stalled while no result is pending.");

   a_stall_rises_on_blocked_beat: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && rsp_valid && rsp_stall))
      else $error("The input stalled without a beat arriving behind a stalled result.");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_cancelled))
      else $error("A stalled result changed or vanished.");

endmodule

bind button_debounce_double_press_core bddp_checker u_bddp_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_event_res(rsp_event_res),
   .rsp_cancelled(rsp_cancelled)
);
